// File: hw/rtl/sxc_pkg.sv
// ----------------------------------------------------------------------------
// sxc_pkg
// Types, constants and register indexes shared by the shift-XOR code encoder.
// ----------------------------------------------------------------------------
package sxc_pkg;

    localparam int FIELD_BITS           = 8;
    localparam int DEF_MAX_CODED_ROWS   = 8;
    localparam int DEF_MAX_MESSAGE_ROWS = 8;
    localparam int DEF_HISTORY_DEPTH    = 64;

    // The flush after a final column never runs longer than this.
    localparam int MAX_FLUSH = 49;
    localparam int FLUSH_W   = 7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATRIX_MODE  = 2'd0,
        CFG_CODED_ROWS   = 2'd1,
        CFG_MESSAGE_ROWS = 2'd2
    } t_cfg_index;

    typedef enum logic {
        MODE_RID      = 1'b0,
        MODE_TWO_TONE = 1'b1
    } t_matrix_mode;

    typedef struct packed {
        t_matrix_mode            matrix_mode;
        logic [CFG_DATA_W-1:0]   coded_rows;
        logic [CFG_DATA_W-1:0]   message_rows;
    } t_sxc_cfg;

    localparam t_sxc_cfg CFG_RESET = '{
        matrix_mode:  MODE_RID,
        coded_rows:   4'd8,
        message_rows: 4'd8
    };

    typedef struct packed {
        logic [FIELD_BITS-1:0] message_bits;
        logic                  last_column;
    } t_sxc_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] coded_bits;
        logic [FIELD_BITS-1:0] row_valid;
        logic                  last;
    } t_sxc_out;

endpackage

// File: hw/rtl/sxc_shift_table.sv
// ----------------------------------------------------------------------------
// sxc_shift_table
// Registered tap shifts, per-row largest shift, flush length and lane and row
// masks, all derived from the configuration registers.
// ----------------------------------------------------------------------------
module sxc_shift_table #(
    parameter int MAX_CODED_ROWS   = sxc_pkg::DEF_MAX_CODED_ROWS,
    parameter int MAX_MESSAGE_ROWS = sxc_pkg::DEF_MAX_MESSAGE_ROWS,
    localparam int OUT_ROWS  = (MAX_CODED_ROWS < sxc_pkg::FIELD_BITS) ?
                               MAX_CODED_ROWS : sxc_pkg::FIELD_BITS,
    localparam int MSG_LANES = (MAX_MESSAGE_ROWS < sxc_pkg::FIELD_BITS) ?
                               MAX_MESSAGE_ROWS : sxc_pkg::FIELD_BITS,
    localparam int SHIFT_W   = $clog2((MAX_CODED_ROWS - 1) * (MAX_MESSAGE_ROWS - 1) + 2)
) (
    input  logic                          i_clk,
    input  sxc_pkg::t_sxc_cfg             i_cfg,
    output logic [SHIFT_W-1:0]            o_shift [OUT_ROWS][MSG_LANES],
    output logic [SHIFT_W-1:0]            o_tmax [OUT_ROWS],
    output logic [sxc_pkg::FLUSH_W-1:0]   o_total,
    output logic [MSG_LANES-1:0]          o_lane_mask,
    output logic [sxc_pkg::FIELD_BITS-1:0] o_row_mask
);
    import sxc_pkg::*;

    localparam int MAX_ROWS = (MAX_CODED_ROWS > MAX_MESSAGE_ROWS) ?
                              MAX_CODED_ROWS : MAX_MESSAGE_ROWS;
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int RAW_W    = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;
    localparam int PROD_W   = 2 * ROW_W;

    logic [RAW_W-1:0] n_raw, k_raw, n_clamp, k_clamp;
    logic [ROW_W-1:0] n_eff, k_eff, half_n, k_less1;
    logic [PROD_W-1:0] total_prod;
    logic [FLUSH_W-1:0] total_c;

    assign n_raw = RAW_W'(i_cfg.coded_rows);
    assign k_raw = RAW_W'(i_cfg.message_rows);

    // A count of zero means one row; counts above the build limit saturate.
    always_comb begin
        if (n_raw == '0) begin
            n_clamp = RAW_W'(1);
        end else if (n_raw > RAW_W'(MAX_CODED_ROWS)) begin
            n_clamp = RAW_W'(MAX_CODED_ROWS);
        end else begin
            n_clamp = n_raw;
        end
        if (k_raw == '0) begin
            k_clamp = RAW_W'(1);
        end else if (k_raw > RAW_W'(MAX_MESSAGE_ROWS)) begin
            k_clamp = RAW_W'(MAX_MESSAGE_ROWS);
        end else begin
            k_clamp = k_raw;
        end
    end

    assign n_eff   = n_clamp[ROW_W-1:0];
    assign k_eff   = k_clamp[ROW_W-1:0];
    assign half_n  = n_eff >> 1;
    assign k_less1 = k_eff - ROW_W'(1);

    // The widest row sets the flush length: the last row in RID mode, row
    // zero in two-tone mode.
    always_comb begin
        if (i_cfg.matrix_mode == MODE_RID) begin
            total_prod = PROD_W'(n_eff - ROW_W'(1)) * PROD_W'(k_less1);
        end else begin
            total_prod = PROD_W'(half_n) * PROD_W'(k_less1);
        end
        if (total_prod > PROD_W'(MAX_FLUSH)) begin
            total_c = FLUSH_W'(MAX_FLUSH);
        end else begin
            total_c = total_prod[FLUSH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_total <= total_c;
    end

    for (genvar i = 0; i < OUT_ROWS; i++) begin : g_row
        logic [ROW_W-1:0]  row_fac;
        logic [PROD_W-1:0] tmax_prod;

        always_comb begin
            if (i_cfg.matrix_mode == MODE_RID) begin
                row_fac = ROW_W'(i);
            end else if (ROW_W'(i) < half_n) begin
                row_fac = half_n - ROW_W'(i);
            end else begin
                row_fac = ROW_W'(i) - half_n;
            end
            tmax_prod = PROD_W'(row_fac) * PROD_W'(k_less1);
        end

        always_ff @(posedge i_clk) begin
            o_tmax[i] <= tmax_prod[SHIFT_W-1:0];
        end

        for (genvar j = 0; j < MSG_LANES; j++) begin : g_lane
            logic [ROW_W-1:0]  lane_fac;
            logic [PROD_W-1:0] shift_prod;

            // Lanes at or above k give a meaningless product here; they are
            // masked out of the XOR by the lane mask.
            always_comb begin
                if (i_cfg.matrix_mode == MODE_TWO_TONE && ROW_W'(i) < half_n) begin
                    lane_fac = k_less1 - ROW_W'(j);
                end else begin
                    lane_fac = ROW_W'(j);
                end
                shift_prod = PROD_W'(row_fac) * PROD_W'(lane_fac);
            end

            always_ff @(posedge i_clk) begin
                o_shift[i][j] <= shift_prod[SHIFT_W-1:0];
            end
        end
    end

    for (genvar j = 0; j < MSG_LANES; j++) begin : g_lane_mask
        always_ff @(posedge i_clk) begin
            o_lane_mask[j] <= (ROW_W'(j) < k_eff);
        end
    end

    for (genvar i = 0; i < FIELD_BITS; i++) begin : g_row_mask
        if (i < OUT_ROWS) begin : g_used
            always_ff @(posedge i_clk) begin
                o_row_mask[i] <= (ROW_W'(i) < n_eff);
            end
        end else begin : g_unused
            assign o_row_mask[i] = 1'b0;
        end
    end

endmodule

// File: hw/rtl/shift_xor_code_encoder.sv
// ----------------------------------------------------------------------------
// shift_xor_code_encoder
// Shift-XOR erasure code encoder: one message column in, one coded column
// out, with a run of zero flush columns after the final message column.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+--------------------
//   input    | in        | i_in_valid / o_in_ready   | i_in_data  (t_sxc_in)
//   output   | out       | o_out_valid / i_out_ready | o_out_data (t_sxc_out)
//   config   | in        | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One column is accepted per cycle while no flush runs and the output is not
// stalled; its result passes from the input register to the result register.
// A final column is followed by T flush columns, one per cycle while the
// output is not stalled, T being the largest row shift capped at 49; new
// requests wait in the input register meanwhile. Reset loads the default
// configuration and clears the shift history. A stall on the output holds
// the result register and, once the input register is full, the input.
// ----------------------------------------------------------------------------
module shift_xor_code_encoder #(
    parameter int MAX_CODED_ROWS   = sxc_pkg::DEF_MAX_CODED_ROWS,
    parameter int MAX_MESSAGE_ROWS = sxc_pkg::DEF_MAX_MESSAGE_ROWS,
    parameter int HISTORY_DEPTH    = sxc_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sxc_pkg::t_sxc_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sxc_pkg::t_sxc_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [sxc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sxc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sxc_pkg::*;

    localparam int OUT_ROWS  = (MAX_CODED_ROWS < FIELD_BITS) ? MAX_CODED_ROWS : FIELD_BITS;
    localparam int MSG_LANES = (MAX_MESSAGE_ROWS < FIELD_BITS) ? MAX_MESSAGE_ROWS : FIELD_BITS;
    localparam int SHIFT_W   = $clog2((MAX_CODED_ROWS - 1) * (MAX_MESSAGE_ROWS - 1) + 2);
    localparam int IDX_W     = $clog2(HISTORY_DEPTH);
    localparam int CMP_W     = (SHIFT_W > IDX_W + 1) ? SHIFT_W : IDX_W + 1;
    localparam int TV_W      = (SHIFT_W > FLUSH_W) ? SHIFT_W : FLUSH_W;

    t_sxc_cfg                r_cfg;
    logic                    r_a_valid;
    t_sxc_in                 r_a;
    logic                    r_out_valid;
    t_sxc_out                r_out, n_out;
    logic                    r_flush_active;
    logic [FLUSH_W-1:0]      r_flush_cnt;
    logic [HISTORY_DEPTH-1:0] r_hist [MSG_LANES];
    logic [HISTORY_DEPTH-1:0] n_push [MSG_LANES];

    logic [SHIFT_W-1:0]      shift [OUT_ROWS][MSG_LANES];
    logic [SHIFT_W-1:0]      tmax [OUT_ROWS];
    logic [FLUSH_W-1:0]      total;
    logic [MSG_LANES-1:0]    lane_mask;
    logic [FIELD_BITS-1:0]   row_mask;

    logic                    src_valid, can_load, issue, terminal, start_flush;
    logic [FLUSH_W-1:0]      flush_col;
    logic [FIELD_BITS-1:0]   coded, flush_valid;

    sxc_shift_table #(
        .MAX_CODED_ROWS   (MAX_CODED_ROWS),
        .MAX_MESSAGE_ROWS (MAX_MESSAGE_ROWS)
    ) u_shift_table (
        .i_clk       (i_clk),
        .i_cfg       (r_cfg),
        .o_shift     (shift),
        .o_tmax      (tmax),
        .o_total     (total),
        .o_lane_mask (lane_mask),
        .o_row_mask  (row_mask)
    );

    // Flush columns take priority over a waiting message column.
    assign src_valid   = r_flush_active | r_a_valid;
    assign can_load    = ~r_out_valid | i_out_ready;
    assign issue       = can_load & src_valid;
    assign o_in_ready  = ~r_a_valid | (issue & ~r_flush_active);
    assign flush_col   = r_flush_cnt + FLUSH_W'(1);
    assign terminal    = r_flush_active ? (flush_col == total)
                                        : (r_a.last_column && total == '0);
    assign start_flush = ~r_flush_active & r_a.last_column & (total != '0);

    always_comb begin
        for (int j = 0; j < MSG_LANES; j++) begin
            n_push[j] = {r_hist[j][HISTORY_DEPTH-2:0],
                         ~r_flush_active & lane_mask[j] & r_a.message_bits[j]};
        end
    end

    // Each coded bit XORs one tap per message lane; taps at or beyond the
    // history depth read as zero.
    always_comb begin
        logic [CMP_W-1:0] s_ext;
        logic             acc;
        coded = '0;
        for (int i = 0; i < OUT_ROWS; i++) begin
            acc = 1'b0;
            for (int j = 0; j < MSG_LANES; j++) begin
                s_ext = CMP_W'(shift[i][j]);
                if (lane_mask[j] && s_ext < CMP_W'(HISTORY_DEPTH)) begin
                    acc = acc ^ n_push[j][s_ext[IDX_W-1:0]];
                end
            end
            coded[i] = acc & row_mask[i];
        end
    end

    always_comb begin
        flush_valid = '0;
        for (int i = 0; i < OUT_ROWS; i++) begin
            flush_valid[i] = row_mask[i] && (TV_W'(flush_col) <= TV_W'(tmax[i]));
        end
    end

    always_comb begin
        n_out.coded_bits = coded;
        n_out.row_valid  = r_flush_active ? flush_valid : row_mask;
        n_out.last       = terminal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= CFG_RESET;
            r_a_valid      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_flush_active <= 1'b0;
            r_flush_cnt    <= '0;
            for (int j = 0; j < MSG_LANES; j++) begin
                r_hist[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MATRIX_MODE:  r_cfg.matrix_mode  <= t_matrix_mode'(i_cfg_data[0]);
                    CFG_CODED_ROWS:   r_cfg.coded_rows   <= i_cfg_data;
                    CFG_MESSAGE_ROWS: r_cfg.message_rows <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && o_in_ready) begin
                r_a_valid <= 1'b1;
            end else if (issue && !r_flush_active) begin
                r_a_valid <= 1'b0;
            end

            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (issue) begin
                for (int j = 0; j < MSG_LANES; j++) begin
                    r_hist[j] <= terminal ? '0 : n_push[j];
                end
                if (r_flush_active) begin
                    if (terminal) begin
                        r_flush_active <= 1'b0;
                        r_flush_cnt    <= '0;
                    end else begin
                        r_flush_cnt <= flush_col;
                    end
                end else if (start_flush) begin
                    r_flush_active <= 1'b1;
                    r_flush_cnt    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a <= i_in_data;
        end
        if (issue) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/sxc_checker.sv
// ----------------------------------------------------------------------------
// sxc_checker
// Port-level checks on the encoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sxc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input sxc_pkg::t_sxc_out o_out_data
);
    import sxc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("stalled result request withdrawn");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result payload changed");

    // A row that is not valid at this position has only flush zeros in its
    // taps, so its coded bit must be clear.
    a_coded_in_valid_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.coded_bits & ~o_out_data.row_valid) == '0))
        else $error("coded bit set on a row that is not valid");

endmodule

bind shift_xor_code_encoder sxc_checker u_sxc_checker (.*);
